// ===== sv/call_event_profile_counters_core_macros.svh =====
// assertion macros for the profiling counter block
// used by the controller; needs only a clock and an active-low reset
`ifndef CALL_EVENT_PROFILE_COUNTERS_CORE_MACROS_SVH
`define CALL_EVENT_PROFILE_COUNTERS_CORE_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define CEPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is asserted
`define CEPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cepc_pkg.sv =====
// shared constants, command codes and control structs of the profiling counters
// no dependencies
package cepc_pkg;

  // default sizes
  localparam int NUM_FDS_DEF   = 64;
  localparam int NUM_REQS_DEF  = 16;
  localparam int NUM_KINDS_DEF = 8;

  // counter word width
  localparam int CNT_W = 32;

  // item commands
  localparam logic [2:0] CMD_RECORD     = 3'd0;
  localparam logic [2:0] CMD_READ_TOTAL = 3'd1;
  localparam logic [2:0] CMD_READ_CELL  = 3'd2;
  localparam logic [2:0] CMD_READ_ENTRY = 3'd3;
  localparam logic [2:0] CMD_CLEAR      = 3'd4;

  // call kind that also goes to the request table
  localparam logic [2:0] KIND_IOCTL = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take the input beat, start the cell read
    logic update;    // apply a record
    logic load_out;  // load the result register
    logic clear;     // zero totals and request counts and times
    logic sweep_we;  // write one zero word of the cell memory
  } cepc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] command;
    logic       sweep_last;
  } cepc_sts_t;

endpackage

// ===== sv/cepc_if.sv =====
// valid/ready channel interfaces for the item and result beats
// no dependencies
interface cepc_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [2:0]         call_kind;
  logic signed [10:0] fd;
  logic [31:0]        elapsed_us;
  logic [31:0]        request_code;
  logic [3:0]         entry_index;

  modport source (output valid, command, call_kind, fd, elapsed_us, request_code,
                  entry_index, input ready);
  modport sink (input valid, command, call_kind, fd, elapsed_us, request_code,
                entry_index, output ready);
endinterface

interface cepc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] count;
  logic [31:0] time_us;
  logic [31:0] code;
  logic        entry_used;

  modport source (output valid, count, time_us, code, entry_used, input ready);
  modport sink (input valid, count, time_us, code, entry_used, output ready);
endinterface

// ===== sv/cepc_dp.sv =====
// datapath: kind totals, request table, cell counter memory and result register
// depends on cepc_pkg
module cepc_dp
  import cepc_pkg::*;
#(
  parameter int NUM_FDS   = NUM_FDS_DEF,
  parameter int NUM_REQS  = NUM_REQS_DEF,
  parameter int NUM_KINDS = NUM_KINDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cepc_cmd_t          cmd,
  output cepc_sts_t          sts,
  input  logic [2:0]         in_command,
  input  logic [2:0]         in_call_kind,
  input  logic signed [10:0] in_fd,
  input  logic [31:0]        in_elapsed_us,
  input  logic [31:0]        in_request_code,
  input  logic [3:0]         in_entry_index,
  output logic [31:0]        out_count,
  output logic [31:0]        out_time_us,
  output logic [31:0]        out_code,
  output logic               out_entry_used
);

  localparam int DEPTH = NUM_KINDS * NUM_FDS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = (NUM_KINDS > 1) ? $clog2(NUM_KINDS) : 1;
  localparam int RW    = (NUM_REQS > 1) ? $clog2(NUM_REQS) : 1;

  // cell memory: {time, count} per kind and descriptor
  logic [2*CNT_W-1:0] mem [DEPTH];
  logic [2*CNT_W-1:0] rd_data_r;

  // flop state
  logic [CNT_W-1:0]    total_r    [NUM_KINDS];
  logic [CNT_W-1:0]    req_code_r [NUM_REQS];
  logic [CNT_W-1:0]    req_cnt_r  [NUM_REQS];
  logic [CNT_W-1:0]    req_time_r [NUM_REQS];

  // captured item
  logic [2:0]          cmd_r;
  logic [2:0]          kind_r;
  logic                kind_ok_r;
  logic                fd_ok_r;
  logic                idx_ok_r;
  logic [RW-1:0]       idx_r;
  logic [AW-1:0]       addr_r;
  logic [CNT_W-1:0]    us_r;
  logic [CNT_W-1:0]    req_r;
  logic [NUM_REQS-1:0] hit_r;

  logic [AW-1:0]       sweep_r;

  logic                in_kind_ok;
  logic                in_fd_ok;
  logic                in_idx_ok;
  logic [AW-1:0]       in_addr;
  logic [NUM_REQS-1:0] in_hit;
  logic [KW-1:0]       kidx;
  logic [RW-1:0]       sel;
  logic                any_hit;
  logic [CNT_W-1:0]    rd_cnt;
  logic [CNT_W-1:0]    rd_time;
  logic                cell_we;
  logic                req_we;
  logic                tot_we;
  logic                mem_we;
  logic [AW-1:0]       mem_wa;
  logic [2*CNT_W-1:0]  mem_wd;

  // item decode at the input beat
  assign in_kind_ok = 5'(in_call_kind) < 5'(NUM_KINDS);
  assign in_fd_ok   = !in_fd[10] && ({1'b0, in_fd[9:0]} < 11'(NUM_FDS));
  assign in_idx_ok  = 7'(in_entry_index) < 7'(NUM_REQS);
  assign in_addr    = AW'(in_call_kind) * AW'(NUM_FDS) + AW'(in_fd[9:0]);

  // request table match or free slot, one compare per entry
  always_comb begin
    for (int i = 0; i < NUM_REQS; i++) begin
      in_hit[i] = (req_cnt_r[i] == '0) || (req_code_r[i] == in_request_code);
    end
  end

  // first matching or free entry
  always_comb begin
    sel     = '0;
    any_hit = 1'b0;
    for (int i = 0; i < NUM_REQS; i++) begin
      if (hit_r[i] && !any_hit) begin
        sel     = RW'(i);
        any_hit = 1'b1;
      end
    end
  end

  assign kidx    = KW'(kind_r);
  assign rd_cnt  = rd_data_r[CNT_W-1:0];
  assign rd_time = rd_data_r[2*CNT_W-1:CNT_W];
  assign tot_we  = cmd.update && kind_ok_r;
  assign cell_we = cmd.update && kind_ok_r && fd_ok_r;
  assign req_we  = cmd.update && kind_ok_r && (kind_r == KIND_IOCTL) && any_hit;

  // memory write port: clearing sweep or record update
  always_comb begin
    mem_we = cmd.sweep_we || cell_we;
    if (cmd.sweep_we) begin
      mem_wa = sweep_r;
      mem_wd = '0;
    end else begin
      mem_wa = addr_r;
      mem_wd = {rd_time + us_r, rd_cnt + CNT_W'(1)};
    end
  end

  // cell memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.capture) begin
      rd_data_r <= mem[in_addr];
    end
  end

  // sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep_we) begin
      sweep_r <= (sweep_r == AW'(DEPTH - 1)) ? '0 : sweep_r + AW'(1);
    end
  end

  assign sts.sweep_last = (sweep_r == AW'(DEPTH - 1));
  assign sts.command    = cmd_r;

  // captured item fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r <= CMD_RECORD;
    end else if (cmd.capture) begin
      cmd_r <= in_command;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r    <= in_call_kind;
      kind_ok_r <= in_kind_ok;
      fd_ok_r   <= in_fd_ok;
      idx_ok_r  <= in_idx_ok;
      idx_r     <= RW'(in_entry_index);
      addr_r    <= in_addr;
      us_r      <= in_elapsed_us;
      req_r     <= in_request_code;
      hit_r     <= in_hit;
    end
  end

  // kind totals
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int k = 0; k < NUM_KINDS; k++) begin
        total_r[k] <= '0;
      end
    end else if (tot_we) begin
      total_r[kidx] <= total_r[kidx] + CNT_W'(1);
    end
  end

  // request table; a clear keeps the codes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REQS; i++) begin
        req_code_r[i] <= '0;
        req_cnt_r[i]  <= '0;
        req_time_r[i] <= '0;
      end
    end else if (cmd.clear) begin
      for (int i = 0; i < NUM_REQS; i++) begin
        req_cnt_r[i]  <= '0;
        req_time_r[i] <= '0;
      end
    end else if (req_we) begin
      req_code_r[sel] <= req_r;
      req_cnt_r[sel]  <= req_cnt_r[sel] + CNT_W'(1);
      req_time_r[sel] <= req_time_r[sel] + us_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      case (cmd_r)
        CMD_READ_TOTAL: begin
          out_count      <= kind_ok_r ? total_r[kidx] : '0;
          out_time_us    <= '0;
          out_code       <= '0;
          out_entry_used <= 1'b0;
        end
        CMD_READ_CELL: begin
          out_count      <= (kind_ok_r && fd_ok_r) ? rd_cnt : '0;
          out_time_us    <= (kind_ok_r && fd_ok_r) ? rd_time : '0;
          out_code       <= '0;
          out_entry_used <= 1'b0;
        end
        CMD_READ_ENTRY: begin
          out_count      <= idx_ok_r ? req_cnt_r[idx_r] : '0;
          out_time_us    <= idx_ok_r ? req_time_r[idx_r] : '0;
          out_code       <= idx_ok_r ? req_code_r[idx_r] : '0;
          out_entry_used <= idx_ok_r && (req_cnt_r[idx_r] != '0);
        end
        default: begin
          out_count      <= '0;
          out_time_us    <= '0;
          out_code       <= '0;
          out_entry_used <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== sv/cepc_ctrl.sv =====
// controller: sequences capture, update, result load and memory clearing sweep
// depends on cepc_pkg and the assertion macro header
`include "call_event_profile_counters_core_macros.svh"

module cepc_ctrl
  import cepc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output cepc_cmd_t cmd,
  input  cepc_sts_t sts
);

  typedef enum logic [1:0] {ST_SWEEP, ST_IDLE, ST_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_fire;
  logic   out_free;
  logic   is_read;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // command decode of the captured item
  always_comb begin
    case (sts.command) inside
      CMD_READ_TOTAL, CMD_READ_CELL, CMD_READ_ENTRY: is_read = 1'b1;
      default:                                       is_read = 1'b0;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.capture  = in_fire;
    cmd.update   = (state_r == ST_EXEC) && (sts.command == CMD_RECORD);
    cmd.load_out = (state_r == ST_EXEC) && is_read && out_free;
    cmd.clear    = (state_r == ST_EXEC) && (sts.command == CMD_CLEAR);
    cmd.sweep_we = (state_r == ST_SWEEP);
  end

  // next state and result valid
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_SWEEP: begin
        if (sts.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (is_read && !out_free) state_nxt = ST_EXEC;
        else if (sts.command == CMD_CLEAR) state_nxt = ST_SWEEP;
        else state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // checks
  `CEPC_ASSERT_NEXT(a_fire_to_exec, clk, rst_n, in_fire, state_r == ST_EXEC, "accepted beat not executed")
  `CEPC_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.load_out, out_free, "result overwrites a waiting beat")
  `CEPC_ASSERT_NOW(a_no_accept_in_sweep, clk, rst_n, cmd.sweep_we, !in_ready, "beat accepted during clearing")
  `CEPC_ASSERT_NEXT(a_clear_sweeps, clk, rst_n, cmd.clear, state_r == ST_SWEEP, "clear without memory sweep")

endmodule

// ===== sv/call_event_profile_counters_core.sv =====
// Profiling counters for intercepted calls. Each item has a capture step and an
// execute step: in the capture step the beat is captured and the per-kind,
// per-descriptor cell memory is read (and the request table is matched in
// parallel), in the execute step the record is written back or the result
// register is loaded; a read waits in its execute step while the previous result
// beat has not been taken. A clear item, and reset, start a clearing pass over all
// NUM_KINDS*NUM_FDS words of the cell memory (512 by default) during which no item
// is accepted; kind totals and the request table live in flops and clear at once.
// depends on cepc_pkg, cepc_if, cepc_ctrl and cepc_dp
module call_event_profile_counters_core
  import cepc_pkg::*;
#(
  parameter int NUM_FDS   = NUM_FDS_DEF,
  parameter int NUM_REQS  = NUM_REQS_DEF,
  parameter int NUM_KINDS = NUM_KINDS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  cepc_in_if.sink    in_if,
  cepc_out_if.source out_if
);

  cepc_cmd_t cmd;
  cepc_sts_t sts;

  // control
  cepc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // counters and result register
  cepc_dp #(
    .NUM_FDS   (NUM_FDS),
    .NUM_REQS  (NUM_REQS),
    .NUM_KINDS (NUM_KINDS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_command      (in_if.command),
    .in_call_kind    (in_if.call_kind),
    .in_fd           (in_if.fd),
    .in_elapsed_us   (in_if.elapsed_us),
    .in_request_code (in_if.request_code),
    .in_entry_index  (in_if.entry_index),
    .out_count       (out_if.count),
    .out_time_us     (out_if.time_us),
    .out_code        (out_if.code),
    .out_entry_used  (out_if.entry_used)
  );

endmodule

// ===== test/cepc_checker.sv =====
// beat monitor, counter predictor and result comparison for the profiling counters
// depends on cepc_pkg and the cepc_in_if / cepc_out_if channel interfaces
module cepc_checker
  import cepc_pkg::*;
#(
  parameter int NUM_FDS   = NUM_FDS_DEF,
  parameter int NUM_REQS  = NUM_REQS_DEF,
  parameter int NUM_KINDS = NUM_KINDS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  cepc_in_if   in_mon,
  cepc_out_if  out_mon,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] count;
    logic [31:0] time_us;
    logic [31:0] code;
    logic        entry_used;
  } read_reply_t;

  // mirrored counter state
  logic [31:0] kind_total [NUM_KINDS];
  logic [31:0] cell_count [NUM_KINDS*NUM_FDS];
  logic [31:0] cell_us    [NUM_KINDS*NUM_FDS];
  logic [31:0] slot_code  [NUM_REQS];
  logic [31:0] slot_count [NUM_REQS];
  logic [31:0] slot_us    [NUM_REQS];

  read_reply_t awaited_replies [$];
  int          errors = 0;

  assign fail_count = errors;

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t ns  mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
  endtask

  // wipe counts and times; the stored request codes survive a clear
  task automatic zero_counters();
    foreach (kind_total[k]) kind_total[k] = '0;
    foreach (cell_count[c]) begin
      cell_count[c] = '0;
      cell_us[c]    = '0;
    end
    foreach (slot_count[s]) begin
      slot_count[s] = '0;
      slot_us[s]    = '0;
    end
  endtask

  // one recorded call: kind total, descriptor cell, request table
  task automatic record_call(input logic [2:0] kind, input logic signed [10:0] fd,
                             input logic [31:0] us, input logic [31:0] code);
    int  desc;
    int  cell_ix;
    bit  placed;
    desc   = fd;
    placed = 1'b0;
    if (int'(kind) >= NUM_KINDS) return;
    kind_total[kind] += 32'd1;
    if (desc >= 0 && desc < NUM_FDS) begin
      cell_ix = int'(kind) * NUM_FDS + desc;
      cell_count[cell_ix] += 32'd1;
      cell_us[cell_ix]    += us;
    end
    if (kind != KIND_IOCTL) return;
    // first slot that is free or already holds this code; dropped when none
    for (int i = 0; i < NUM_REQS && !placed; i++) begin
      if (slot_count[i] == '0 || slot_code[i] == code) begin
        slot_code[i]  = code;
        slot_count[i] += 32'd1;
        slot_us[i]    += us;
        placed        = 1'b1;
      end
    end
  endtask

  // apply one accepted item beat, queueing the reply of a read
  task automatic account_beat();
    read_reply_t reply;
    int          desc;
    int          cell_ix;
    reply = '0;
    desc  = in_mon.fd;
    case (in_mon.command)
      CMD_RECORD: record_call(in_mon.call_kind, in_mon.fd, in_mon.elapsed_us,
                              in_mon.request_code);
      CMD_READ_TOTAL: begin
        if (int'(in_mon.call_kind) < NUM_KINDS) reply.count = kind_total[in_mon.call_kind];
        awaited_replies.push_back(reply);
      end
      CMD_READ_CELL: begin
        if (int'(in_mon.call_kind) < NUM_KINDS && desc >= 0 && desc < NUM_FDS) begin
          cell_ix       = int'(in_mon.call_kind) * NUM_FDS + desc;
          reply.count   = cell_count[cell_ix];
          reply.time_us = cell_us[cell_ix];
        end
        awaited_replies.push_back(reply);
      end
      CMD_READ_ENTRY: begin
        if (int'(in_mon.entry_index) < NUM_REQS) begin
          reply.count      = slot_count[in_mon.entry_index];
          reply.time_us    = slot_us[in_mon.entry_index];
          reply.code       = slot_code[in_mon.entry_index];
          reply.entry_used = (reply.count != '0);
        end
        awaited_replies.push_back(reply);
      end
      CMD_CLEAR: zero_counters();
      default: ;
    endcase
  endtask

  // result beats are matched before the item beat of the same edge is applied
  always @(posedge clk) begin : watch
    read_reply_t want;
    if (!rst_n) begin
      zero_counters();
      foreach (slot_code[s]) slot_code[s] = '0;
      awaited_replies.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("result beat with no read waiting");
        end else begin
          want = awaited_replies.pop_front();
          check_field("count", out_mon.count, want.count);
          check_field("time_us", out_mon.time_us, want.time_us);
          check_field("code", out_mon.code, want.code);
          check_field("entry_used", 32'(out_mon.entry_used), 32'(want.entry_used));
        end
      end
      if (in_mon.valid && in_mon.ready) account_beat();
    end
    outstanding = awaited_replies.size();
  end

endmodule

// ===== test/tb_top.sv =====
// top of the profiling counter testbench: clock, reset, item and result drivers,
// watchdog and verdict; depends on cepc_pkg, cepc_if, the core and cepc_checker
module tb_top
  import cepc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         ITEM_TARGET = 1000;
  localparam int         QUIET_LIMIT = 4000;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         POOL_SIZE = 12;
  localparam logic [2:0] CMD_NONE_LO = CMD_CLEAR + 3'd1;
  localparam logic [2:0] KIND_READ   = 3'd0;
  localparam logic [2:0] KIND_WRITE  = 3'd1;
  localparam logic [2:0] KIND_WRITEV = 3'd3;
  localparam logic [2:0] KIND_POLL   = 3'd6;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_reads;
  int   quiet_cycles = 0;
  bit   no_idle = 1'b0;
  logic [31:0] code_pool [POOL_SIZE];

  cepc_in_if  in_if ();
  cepc_out_if out_if ();

  call_event_profile_counters_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  cepc_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count  (fail_count),
    .outstanding (pending_reads)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // wait drawn per beat on either side, none during calm stretches
  function automatic int pause_len();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  // mostly valid descriptors, some -1, the rest anything in 11 bits
  function automatic logic signed [10:0] draw_fd();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return 11'($urandom_range(0, NUM_FDS_DEF - 1));
    if (roll == 7) return 11'h7FF;
    return 11'($urandom_range(0, 2047));
  endfunction

  // small times, full range, times near the top so sums wrap, and zero
  function automatic logic [31:0] draw_us();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1000);
      1: return $urandom();
      2: return 32'hFFFF_FFFF - $urandom_range(0, 255);
      default: return '0;
    endcase
  endfunction

  // codes mostly from a small pool so slots get matched
  function automatic logic [31:0] draw_code();
    if ($urandom_range(0, 99) < 85) return code_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  // one item beat; entered and left at a falling edge
  task automatic send_beat(input logic [2:0] cmd, input logic [2:0] kind,
                           input logic signed [10:0] fd, input logic [31:0] us,
                           input logic [31:0] code, input logic [3:0] idx);
    int gap;
    gap = pause_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.command      <= cmd;
    in_if.call_kind    <= kind;
    in_if.fd           <= fd;
    in_if.elapsed_us   <= us;
    in_if.request_code <= code;
    in_if.entry_index  <= idx;
    in_if.valid        <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // result side: random back-pressure per beat
  initial begin : result_sink
    int hold;
    out_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      hold = pause_len();
      if (hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
      @(negedge clk);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int          sent;
    int          roll;
    logic [2:0]  kind;
    in_if.valid        = 1'b0;
    in_if.command      = CMD_RECORD;
    in_if.call_kind    = KIND_READ;
    in_if.fd           = '0;
    in_if.elapsed_us   = '0;
    in_if.request_code = '0;
    in_if.entry_index  = '0;
    sent = 0;

    foreach (code_pool[p]) code_pool[p] = $urandom();
    code_pool[0] = '0;
    code_pool[1] = 32'hFFFF_FFFF;

    // synchronous reset, then the clearing pass runs behind ready
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // everything reads zero straight after reset
    send_beat(CMD_READ_TOTAL, KIND_READ, 11'sd0, '0, '0, 4'd0);
    send_beat(CMD_READ_CELL, KIND_IOCTL, 11'sd63, '0, '0, 4'd0);
    send_beat(CMD_READ_ENTRY, KIND_READ, 11'sd0, '0, '0, 4'd15);
    // untimed call, and a cell whose time wraps
    send_beat(CMD_RECORD, KIND_READ, 11'sd0, '0, '0, 4'd0);
    send_beat(CMD_RECORD, KIND_WRITEV, 11'sd63, 32'hFFFF_FFFF, '0, 4'd0);
    send_beat(CMD_RECORD, KIND_WRITEV, 11'sd63, 32'hFFFF_FFFF, '0, 4'd0);
    // descriptors outside the cell range only bump the total
    send_beat(CMD_RECORD, KIND_WRITE, 11'h7FF, 32'd5, '0, 4'd0);
    send_beat(CMD_RECORD, KIND_WRITE, 11'sd64, 32'd5, '0, 4'd0);
    send_beat(CMD_RECORD, KIND_POLL, 11'h3FF, 32'd7, '0, 4'd0);
    send_beat(CMD_RECORD, KIND_POLL, 11'h400, 32'd7, '0, 4'd0);
    // request table: new code, zero code, repeat of the first
    send_beat(CMD_RECORD, KIND_IOCTL, 11'sd5, 32'hFFFF_FF00, 32'hFFFF_FFFF, 4'd0);
    send_beat(CMD_RECORD, KIND_IOCTL, 11'h7FF, 32'd3, 32'h0, 4'd0);
    send_beat(CMD_RECORD, KIND_IOCTL, 11'sd5, 32'h0000_0200, 32'hFFFF_FFFF, 4'd0);
    send_beat(CMD_READ_TOTAL, KIND_IOCTL, 11'sd0, '0, '0, 4'd0);
    send_beat(CMD_READ_TOTAL, KIND_WRITE, 11'sd0, '0, '0, 4'd0);
    send_beat(CMD_READ_CELL, KIND_WRITEV, 11'sd63, '0, '0, 4'd0);
    send_beat(CMD_READ_CELL, KIND_WRITE, 11'h7FF, '0, '0, 4'd0);
    send_beat(CMD_READ_CELL, KIND_POLL, 11'h3FF, '0, '0, 4'd0);
    send_beat(CMD_READ_ENTRY, KIND_READ, 11'sd0, '0, '0, 4'd0);
    send_beat(CMD_READ_ENTRY, KIND_READ, 11'sd0, '0, '0, 4'd1);
    // unknown commands are dropped without a reply
    for (int u = 0; u < 3; u++)
      send_beat(CMD_NONE_LO + 3'(u), KIND_IOCTL, 11'sd1, 32'd9, 32'd9, 4'd0);
    // clear keeps the stored codes
    send_beat(CMD_CLEAR, KIND_READ, 11'sd0, '0, '0, 4'd0);
    send_beat(CMD_READ_ENTRY, KIND_READ, 11'sd0, '0, '0, 4'd0);
    send_beat(CMD_READ_TOTAL, KIND_IOCTL, 11'sd0, '0, '0, 4'd0);

    // random mix of records and reads, with occasional table fills and clears
    while (sent < ITEM_TARGET) begin
      if ($urandom_range(0, 39) == 0) no_idle = ($urandom_range(0, 2) == 0);
      roll = $urandom_range(0, 99);
      kind = ($urandom_range(0, 2) == 0) ? KIND_IOCTL : 3'($urandom_range(0, 7));
      if (roll < 1) begin
        // flood the table with 12 to 20 fresh codes, which can overflow it, then walk it
        repeat ($urandom_range(12, 20)) begin
          send_beat(CMD_RECORD, KIND_IOCTL, draw_fd(), draw_us(), $urandom(),
                    4'($urandom_range(0, 15)));
          sent++;
        end
        for (int s = 0; s < NUM_REQS_DEF; s++) begin
          send_beat(CMD_READ_ENTRY, kind, draw_fd(), draw_us(), draw_code(), 4'(s));
          sent++;
        end
      end else if (roll < 3) begin
        send_beat(CMD_CLEAR, kind, draw_fd(), draw_us(), draw_code(),
                  4'($urandom_range(0, 15)));
        sent++;
      end else if (roll < 6) begin
        send_beat(CMD_NONE_LO + 3'($urandom_range(0, 2)), kind, draw_fd(), draw_us(),
                  draw_code(), 4'($urandom_range(0, 15)));
      end else begin
        if (roll < 55)
          send_beat(CMD_RECORD, kind, draw_fd(), draw_us(), draw_code(),
                    4'($urandom_range(0, 15)));
        else if (roll < 67)
          send_beat(CMD_READ_TOTAL, kind, draw_fd(), draw_us(), draw_code(),
                    4'($urandom_range(0, 15)));
        else if (roll < 82)
          send_beat(CMD_READ_CELL, kind, draw_fd(), draw_us(), draw_code(),
                    4'($urandom_range(0, 15)));
        else
          send_beat(CMD_READ_ENTRY, kind, draw_fd(), draw_us(), draw_code(),
                    4'($urandom_range(0, 15)));
        sent++;
      end
    end
    in_if.valid <= 1'b0;

    // drain outstanding reads, then watch a little longer for stray beats
    while (pending_reads != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
